### src/matrix_matrix_multiply_assert.svh
// ---------------------------------------------------------------------------
// matrix_matrix_multiply_assert.svh
// Assertion macros for the matrix multiply block
// ---------------------------------------------------------------------------
`ifndef MATRIX_MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MATRIX_MULTIPLY_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### src/mmm_pkg.sv
// ---------------------------------------------------------------------------
// mmm_pkg
// Shared constants, codes and helpers of the matrix multiply block
// ---------------------------------------------------------------------------
package mmm_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int ACC_WIDTH   = 64;
    localparam int FIELD_WIDTH = 32;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int CMD_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD_A   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_B   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MULTIPLY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS = 3'd5;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    // zero acts as one, anything above MAX_DIM acts as MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // row-major address of element (r, c)
    function automatic logic [ADDR_W-1:0] store_addr(input logic [IDX_W-1:0] r,
                                                     input logic [IDX_W-1:0] c);
        return ADDR_W'(ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c));
    endfunction

    function automatic logic in_range(input logic [IDX_W-1:0] v);
        return ({1'b0, v} < (IDX_W + 1)'(MAX_DIM));
    endfunction

endpackage

### src/mmm_ram.sv
// ---------------------------------------------------------------------------
// mmm_ram
// Generic single-write, single-read RAM with registered read data
// ---------------------------------------------------------------------------
module mmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/mmm_mac.sv
// ---------------------------------------------------------------------------
// mmm_mac
// Multiply, round to Q16.16, accumulate in 64 bits, saturate the sum
// ---------------------------------------------------------------------------
module mmm_mac (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_clear,
    input  logic                                   i_valid,
    input  logic signed [mmm_pkg::DATA_WIDTH-1:0]  i_a,
    input  logic signed [mmm_pkg::DATA_WIDTH-1:0]  i_b,
    output logic                                   o_busy,
    output logic signed [mmm_pkg::DATA_WIDTH-1:0]  o_sum
);

    localparam int PW = 2 * mmm_pkg::DATA_WIDTH;
    localparam int AW = mmm_pkg::ACC_WIDTH;
    localparam int QW = AW - mmm_pkg::FRAC_BITS;

    logic                 r_vp;
    logic                 r_vq;
    logic signed [PW-1:0] r_p;
    logic signed [QW-1:0] r_q;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] p_round;
    logic signed [AW-1:0] n_acc;
    logic                 ovf;

    // round to nearest, ties up: floor((p + 2^15) / 2^16)
    assign p_round = AW'(r_p) + (AW'(1) <<< (mmm_pkg::FRAC_BITS - 1));
    assign n_acc   = r_acc + AW'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vq <= 1'b0;
        end else begin
            r_vp <= i_valid;
            r_vq <= r_vp;
        end
        r_p <= i_a * i_b;
        r_q <= QW'(p_round >>> mmm_pkg::FRAC_BITS);
        if (i_clear) begin
            r_acc <= '0;
        end else if (r_vq) begin
            r_acc <= n_acc;
        end
    end

    // in range when all bits above the result's sign bit match it
    assign ovf = !((&r_acc[AW-1:mmm_pkg::DATA_WIDTH-1]) ||
                   !(|r_acc[AW-1:mmm_pkg::DATA_WIDTH-1]));

    always_comb begin
        if (!ovf) begin
            o_sum = r_acc[mmm_pkg::DATA_WIDTH-1:0];
        end else if (r_acc[AW-1]) begin
            o_sum = {1'b1, {(mmm_pkg::DATA_WIDTH-1){1'b0}}};
        end else begin
            o_sum = {1'b0, {(mmm_pkg::DATA_WIDTH-1){1'b1}}};
        end
    end

    assign o_busy = r_vp | r_vq;

endmodule

### src/matrix_matrix_multiply.sv
// ---------------------------------------------------------------------------
// matrix_matrix_multiply
// Loads A and B into two row-major RAMs and streams out A times B
//
//   channel  direction  signals
//   in       sink       i_in_valid / o_in_ready, command, row, col, element
//   out      source     o_out_valid / i_out_ready, row, col, product, last, status
//   cfg      sink       i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// Load transfers are accepted back to back while the block is idle.
// A multiply issues one RAM read per inner step, then lets the
// multiply/round/accumulate pipeline drain for each element.
// Input is held off while a multiply runs; a waiting result stalls the engine.
// Synchronous active-low reset; RAM contents are not cleared.
// ---------------------------------------------------------------------------
module matrix_matrix_multiply (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [mmm_pkg::CMD_W-1:0]               i_command,
    input  logic [mmm_pkg::IDX_W-1:0]               i_row_index,
    input  logic [mmm_pkg::IDX_W-1:0]               i_col_index,
    input  logic signed [mmm_pkg::FIELD_WIDTH-1:0]  i_element_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [mmm_pkg::IDX_W-1:0]               o_out_row,
    output logic [mmm_pkg::IDX_W-1:0]               o_out_col,
    output logic signed [mmm_pkg::FIELD_WIDTH-1:0]  o_product_value,
    output logic                                    o_last,
    output logic                                    o_status,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [mmm_pkg::CFG_IDX_W-1:0]           i_cfg_index,
    input  logic [mmm_pkg::DIM_W-1:0]               i_cfg_data
);

`include "matrix_matrix_multiply_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN,
        S_PUSH,
        S_ERR
    } t_state;

    t_state r_state;

    logic [mmm_pkg::DIM_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [mmm_pkg::DIM_W-1:0] r_out_rows, r_out_cols;
    logic [mmm_pkg::DIM_W-1:0] r_ar, r_ac, r_bc;
    logic [mmm_pkg::IDX_W-1:0] r_row, r_col, r_k;
    logic                      r_issue_d;

    logic                                   r_out_valid;
    logic [mmm_pkg::IDX_W-1:0]              r_out_row, r_out_col;
    logic signed [mmm_pkg::FIELD_WIDTH-1:0] r_out_value;
    logic                                   r_out_last, r_out_status;

    logic [mmm_pkg::DIM_W-1:0] ar_c, ac_c, br_c, bc_c, or_c, oc_c;
    logic                      in_acc, cfg_acc, out_acc, out_free;
    logic                      load_ok, we_a, we_b, mismatch;
    logic                      issue, k_last, row_last, col_last;
    logic                      mac_clear, mac_busy;
    logic [mmm_pkg::ADDR_W-1:0]             waddr, a_raddr, b_raddr;
    logic [mmm_pkg::DATA_WIDTH-1:0]         wdata, a_rdata, b_rdata;
    logic signed [mmm_pkg::DATA_WIDTH-1:0]  mac_sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid & o_in_ready;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign out_acc     = r_out_valid & i_out_ready;
    assign out_free    = !r_out_valid | i_out_ready;

    assign ar_c = mmm_pkg::clamp_dim(r_a_rows);
    assign ac_c = mmm_pkg::clamp_dim(r_a_cols);
    assign br_c = mmm_pkg::clamp_dim(r_b_rows);
    assign bc_c = mmm_pkg::clamp_dim(r_b_cols);
    assign or_c = mmm_pkg::clamp_dim(r_out_rows);
    assign oc_c = mmm_pkg::clamp_dim(r_out_cols);
    assign mismatch = (ac_c != br_c) || (ar_c != or_c) || (bc_c != oc_c);

    // loads write straight into the stores
    assign load_ok = in_acc && mmm_pkg::in_range(i_row_index) &&
                     mmm_pkg::in_range(i_col_index);
    assign we_a    = load_ok && (i_command == mmm_pkg::CMD_LOAD_A);
    assign we_b    = load_ok && (i_command == mmm_pkg::CMD_LOAD_B);
    assign waddr   = mmm_pkg::store_addr(i_row_index, i_col_index);
    assign wdata   = i_element_value[mmm_pkg::DATA_WIDTH-1:0];

    assign issue    = (r_state == S_ISSUE);
    assign a_raddr  = mmm_pkg::store_addr(r_row, r_k);
    assign b_raddr  = mmm_pkg::store_addr(r_k, r_col);
    assign k_last   = ({1'b0, r_k} + 1'b1) == r_ac;
    assign row_last = ({1'b0, r_row} + 1'b1) == r_ar;
    assign col_last = ({1'b0, r_col} + 1'b1) == r_bc;

    // accumulator restarts before each element's first product
    assign mac_clear = (in_acc && (i_command == mmm_pkg::CMD_MULTIPLY) && !mismatch) ||
                       (r_state == S_PUSH && out_free && !(row_last && col_last));

    mmm_ram #(
        .WIDTH (mmm_pkg::DATA_WIDTH),
        .DEPTH (mmm_pkg::STORE_DEPTH)
    ) u_a_store (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    mmm_ram #(
        .WIDTH (mmm_pkg::DATA_WIDTH),
        .DEPTH (mmm_pkg::STORE_DEPTH)
    ) u_b_store (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    mmm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (mac_clear),
        .i_valid (r_issue_d),
        .i_a     (a_rdata),
        .i_b     (b_rdata),
        .o_busy  (mac_busy),
        .o_sum   (mac_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issue_d   <= 1'b0;
            r_out_valid <= 1'b0;
            r_a_rows    <= mmm_pkg::DIM_RESET;
            r_a_cols    <= mmm_pkg::DIM_RESET;
            r_b_rows    <= mmm_pkg::DIM_RESET;
            r_b_cols    <= mmm_pkg::DIM_RESET;
            r_out_rows  <= mmm_pkg::DIM_RESET;
            r_out_cols  <= mmm_pkg::DIM_RESET;
        end else begin
            r_issue_d <= issue;
            // PUSH and ERR reload the output register themselves on a transfer
            if (out_acc && (r_state != S_PUSH) && (r_state != S_ERR)) begin
                r_out_valid <= 1'b0;
            end

            if (cfg_acc) begin
                unique case (i_cfg_index)
                    mmm_pkg::REG_A_ROWS:   r_a_rows   <= i_cfg_data;
                    mmm_pkg::REG_A_COLS:   r_a_cols   <= i_cfg_data;
                    mmm_pkg::REG_B_ROWS:   r_b_rows   <= i_cfg_data;
                    mmm_pkg::REG_B_COLS:   r_b_cols   <= i_cfg_data;
                    mmm_pkg::REG_OUT_ROWS: r_out_rows <= i_cfg_data;
                    mmm_pkg::REG_OUT_COLS: r_out_cols <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (i_command == mmm_pkg::CMD_MULTIPLY)) begin
                        r_ar    <= ar_c;
                        r_ac    <= ac_c;
                        r_bc    <= bc_c;
                        r_row   <= '0;
                        r_col   <= '0;
                        r_k     <= '0;
                        r_state <= mismatch ? S_ERR : S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (k_last) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (!r_issue_d && !mac_busy) begin
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_row    <= r_row;
                        r_out_col    <= r_col;
                        r_out_value  <= mmm_pkg::FIELD_WIDTH'(mac_sum);
                        r_out_last   <= row_last && col_last;
                        r_out_status <= 1'b0;
                        r_k          <= '0;
                        if (row_last && col_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ISSUE;
                            if (col_last) begin
                                r_col <= '0;
                                r_row <= r_row + 1'b1;
                            end else begin
                                r_col <= r_col + 1'b1;
                            end
                        end
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_row    <= '0;
                        r_out_col    <= '0;
                        r_out_value  <= '0;
                        r_out_last   <= 1'b1;
                        r_out_status <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_product_value = r_out_value;
    assign o_last          = r_out_last;
    assign o_status        = r_out_status;

    `MMM_ASSERT_NOW(a_err_is_last, r_out_valid && r_out_status, r_out_last,
        "mismatch result without last mark")
    `MMM_ASSERT_NOW(a_k_in_range, r_state == S_ISSUE, ({1'b0, r_k} < r_ac),
        "inner index past a_cols")
    `MMM_ASSERT_NOW(a_idle_quiet, o_in_ready, !r_issue_d && !mac_busy,
        "input taken while products in flight")
    `MMM_ASSERT_NEXT(a_push_moves, r_state == S_PUSH && out_free, r_out_valid,
        "element result not registered")

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix_matrix_multiply: loads A and B through the
// input channel, issues multiplies under a range of shape settings, and
// compares every streamed element against a bit-exact Q16.16 predictor with
// random idle gaps on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mmm_pkg::*;

    localparam int ITEM_TARGET   = 160;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTS    = 100;

    // command code the block ignores, and register indexes with no register
    localparam logic [CMD_W-1:0]     CMD_RESERVED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7  = 3'd7;

    class product_checker;
        typedef struct {
            logic [IDX_W-1:0]              row;
            logic [IDX_W-1:0]              col;
            logic signed [FIELD_WIDTH-1:0] value;
            logic                          last;
            logic                          status;
        } t_product;

        logic signed [DATA_WIDTH-1:0] a_mem [STORE_DEPTH];
        logic signed [DATA_WIDTH-1:0] b_mem [STORE_DEPTH];
        logic [DIM_W-1:0]             dims [6];
        t_product                     expected_products [$];
        int                           errors;

        function new();
            errors = 0;
            foreach (dims[i]) dims[i] = DIM_RESET;
            foreach (a_mem[i]) begin
                a_mem[i] = '0;
                b_mem[i] = '0;
            end
        endfunction

        function int dim_of(logic [CFG_IDX_W-1:0] idx);
            logic [DIM_W-1:0] v;
            v = dims[int'(idx)];
            if (v == '0) return 1;
            if (v > MAX_DIM) return MAX_DIM;
            return int'(v);
        endfunction

        function bit shapes_agree();
            return dim_of(REG_A_COLS) == dim_of(REG_B_ROWS) &&
                   dim_of(REG_A_ROWS) == dim_of(REG_OUT_ROWS) &&
                   dim_of(REG_B_COLS) == dim_of(REG_OUT_COLS);
        endfunction

        function void write_dim(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
            if (idx <= REG_OUT_COLS) dims[int'(idx)] = data;
        endfunction

        function void predict_products();
            int       ar, ac, bc, r, c, k;
            longint   acc, prod, sat_hi, sat_lo, half_lsb;
            t_product p;
            sat_hi   = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
            sat_lo   = -sat_hi - 1;
            half_lsb = longint'(1) <<< (FRAC_BITS - 1);
            if (!shapes_agree()) begin
                p.row    = '0;
                p.col    = '0;
                p.value  = '0;
                p.last   = 1'b1;
                p.status = 1'b1;
                expected_products.push_back(p);
                return;
            end
            ar = dim_of(REG_A_ROWS);
            ac = dim_of(REG_A_COLS);
            bc = dim_of(REG_B_COLS);
            for (r = 0; r < ar; r++) begin
                for (c = 0; c < bc; c++) begin
                    acc = 0;
                    for (k = 0; k < ac; k++) begin
                        prod = longint'(a_mem[r * MAX_DIM + k]) *
                               longint'(b_mem[k * MAX_DIM + c]);
                        // round each product to nearest, ties toward +inf
                        acc += (prod + half_lsb) >>> FRAC_BITS;
                    end
                    if (acc > sat_hi) acc = sat_hi;
                    if (acc < sat_lo) acc = sat_lo;
                    p.row    = IDX_W'(r);
                    p.col    = IDX_W'(c);
                    p.value  = acc[FIELD_WIDTH-1:0];
                    p.last   = (r == ar - 1) && (c == bc - 1);
                    p.status = 1'b0;
                    expected_products.push_back(p);
                end
            end
        endfunction

        function void note_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                                logic [IDX_W-1:0] col, logic [FIELD_WIDTH-1:0] value);
            int addr;
            addr = int'(row) * MAX_DIM + int'(col);
            case (cmd)
                CMD_LOAD_A:   a_mem[addr] = value[DATA_WIDTH-1:0];
                CMD_LOAD_B:   b_mem[addr] = value[DATA_WIDTH-1:0];
                CMD_MULTIPLY: predict_products();
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_products.size();
        endfunction

        task report(string msg);
            errors++;
            // keep the log short if the block is badly broken
            if (errors <= MAX_PRINTS) $display("MISMATCH: %s", msg);
        endtask

        task check_product(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                           logic signed [FIELD_WIDTH-1:0] value, logic last,
                           logic status);
            t_product want;
            if (expected_products.size() == 0) begin
                report($sformatf("unexpected result row %0d col %0d value %h",
                                 row, col, value));
                return;
            end
            want = expected_products.pop_front();
            if (row !== want.row)
                report($sformatf("row %0d, expected %0d", row, want.row));
            if (col !== want.col)
                report($sformatf("col %0d, expected %0d", col, want.col));
            if (value !== want.value)
                report($sformatf("value %h, expected %h at (%0d,%0d)",
                                 value, want.value, want.row, want.col));
            if (last !== want.last)
                report($sformatf("last %b, expected %b at (%0d,%0d)",
                                 last, want.last, want.row, want.col));
            if (status !== want.status)
                report($sformatf("status %b, expected %b", status, want.status));
        endtask
    endclass

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_ready;
    logic [CMD_W-1:0]              i_command       = CMD_LOAD_A;
    logic [IDX_W-1:0]              i_row_index     = '0;
    logic [IDX_W-1:0]              i_col_index     = '0;
    logic signed [FIELD_WIDTH-1:0] i_element_value = '0;
    logic                          o_out_valid;
    logic                          i_out_ready     = 1'b0;
    logic [IDX_W-1:0]              o_out_row;
    logic [IDX_W-1:0]              o_out_col;
    logic signed [FIELD_WIDTH-1:0] o_product_value;
    logic                          o_last;
    logic                          o_status;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index     = REG_A_ROWS;
    logic [DIM_W-1:0]              i_cfg_data      = '0;

    product_checker products;
    bit             a_written [STORE_DEPTH];
    bit             b_written [STORE_DEPTH];
    bit             in_calm = 1'b0;
    int             items_sent = 0;
    int             cycle_count = 0;

    matrix_matrix_multiply dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_product_value (o_product_value),
        .o_last          (o_last),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: random stall per transfer, with calm stretches
    initial begin : result_sink
        int stall;
        bit calm;
        calm = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 23) == 0) calm = !calm;
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            products.check_product(o_out_row, o_out_col, o_product_value, o_last, o_status);
        end
    end

    function automatic logic [FIELD_WIDTH-1:0] rand_elem();
        logic [FIELD_WIDTH-1:0] v;
        int                     pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            v = $urandom;
        end else if (pick < 8) begin
            // within +/-8.0, where sums stay clear of saturation
            v = $urandom_range(0, 32'h0007_FFFF);
            if ($urandom_range(0, 1) == 1) v = -v;
        end else begin
            case ($urandom_range(0, 5))
                0: v = 32'h7FFF_FFFF;
                1: v = 32'h8000_0000;
                2: v = 32'h0001_0000;
                3: v = 32'hFFFF_0000;
                4: v = 32'hFFFF_FFFF;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    function automatic int draw_dim();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_DIM) : $urandom_range(1, 3);
    endfunction

    // register code that acts as the given size, using 0 and values above
    // MAX_DIM half of the time where they apply
    function automatic logic [DIM_W-1:0] pick_code(int dim);
        if (dim == 1 && $urandom_range(0, 1) == 1) return '0;
        if (dim == MAX_DIM && $urandom_range(0, 1) == 1)
            return DIM_W'($urandom_range(MAX_DIM + 1, 15));
        return DIM_W'(dim);
    endfunction

    task automatic push_item(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic [FIELD_WIDTH-1:0] value);
        int gap;
        if ($urandom_range(0, 23) == 0) in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_command       <= cmd;
        i_row_index     <= row;
        i_col_index     <= col;
        i_element_value <= value;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        products.note_item(cmd, row, col, value);
        if (cmd == CMD_LOAD_A) a_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
        if (cmd == CMD_LOAD_B) b_written[int'(row) * MAX_DIM + int'(col)] = 1'b1;
        if (cmd != CMD_RESERVED) items_sent++;
    endtask

    task automatic drain_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (products.pending() != 0) @(posedge i_clk);
    endtask

    // idle the block fully, including any load still in flight
    task automatic settle();
        drain_input();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        products.write_dim(idx, data);
        i_cfg_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [DIM_W-1:0] a_rows, logic [DIM_W-1:0] a_cols,
                            logic [DIM_W-1:0] b_rows, logic [DIM_W-1:0] b_cols,
                            logic [DIM_W-1:0] out_rows, logic [DIM_W-1:0] out_cols);
        settle();
        cfg_write(REG_A_ROWS, a_rows);
        cfg_write(REG_A_COLS, a_cols);
        cfg_write(REG_B_ROWS, b_rows);
        cfg_write(REG_B_COLS, b_cols);
        cfg_write(REG_OUT_ROWS, out_rows);
        cfg_write(REG_OUT_COLS, out_cols);
    endtask

    // load every operand entry the next multiply reads that was never written
    task automatic fill_operands();
        int ar, ac, bc, r, c, k;
        if (!products.shapes_agree()) return;
        ar = products.dim_of(REG_A_ROWS);
        ac = products.dim_of(REG_A_COLS);
        bc = products.dim_of(REG_B_COLS);
        for (r = 0; r < ar; r++)
            for (k = 0; k < ac; k++)
                if (!a_written[r * MAX_DIM + k])
                    push_item(CMD_LOAD_A, IDX_W'(r), IDX_W'(k), rand_elem());
        for (k = 0; k < ac; k++)
            for (c = 0; c < bc; c++)
                if (!b_written[k * MAX_DIM + c])
                    push_item(CMD_LOAD_B, IDX_W'(k), IDX_W'(c), rand_elem());
    endtask

    task automatic multiply();
        fill_operands();
        push_item(CMD_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), $urandom);
    endtask

    initial begin : stimulus
        int               ar, ac, bc, loads, muls, phase;
        logic [IDX_W-1:0] r, c;
        logic [CMD_W-1:0] cmd;
        products = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // 1x1 products at the format extremes
        set_dims(4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
        push_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        push_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        multiply();
        push_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        multiply();
        push_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        multiply();
        // half-LSB products: positive tie rounds up, negative tie rounds to zero
        push_item(CMD_LOAD_A, 3'd0, 3'd0, 32'h0000_0001);
        push_item(CMD_LOAD_B, 3'd0, 3'd0, 32'h0000_8000);
        multiply();
        push_item(CMD_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
        multiply();
        push_item(CMD_RESERVED, 3'd7, 3'd7, $urandom);
        push_item(CMD_LOAD_A, 3'd7, 3'd7, rand_elem());
        push_item(CMD_LOAD_B, 3'd7, 3'd7, rand_elem());

        // writes to indexes with no register behind them
        settle();
        cfg_write(REG_SPARE_6, 4'hF);
        cfg_write(REG_SPARE_7, 4'h0);

        // inner size, row and column disagreements
        set_dims(4'd0, 4'd3, 4'd2, 4'd15, 4'd1, 4'd8);
        multiply();
        set_dims(4'd2, 4'd2, 4'd2, 4'd2, 4'd3, 4'd2);
        multiply();
        set_dims(4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd1);
        multiply();

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (phase == 0) begin
                // column times row: the full 8x8 output
                set_dims(pick_code(MAX_DIM), pick_code(1), pick_code(1),
                         pick_code(MAX_DIM), pick_code(MAX_DIM), pick_code(MAX_DIM));
            end else if (phase == 1) begin
                // row times column: the longest inner sum
                set_dims(pick_code(1), pick_code(MAX_DIM), pick_code(MAX_DIM),
                         pick_code(1), pick_code(1), pick_code(1));
            end else if ($urandom_range(0, 5) == 0) begin
                set_dims(DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom),
                         DIM_W'($urandom), DIM_W'($urandom), DIM_W'($urandom));
            end else begin
                ar = draw_dim();
                ac = draw_dim();
                bc = draw_dim();
                set_dims(pick_code(ar), pick_code(ac), pick_code(ac),
                         pick_code(bc), pick_code(ar), pick_code(bc));
            end
            ar = products.dim_of(REG_A_ROWS);
            ac = products.dim_of(REG_A_COLS);
            bc = products.dim_of(REG_B_COLS);
            muls = $urandom_range(1, 3);
            repeat (muls) begin
                loads = $urandom_range(0, 6);
                repeat (loads) begin
                    cmd = ($urandom_range(0, 1) == 1) ? CMD_LOAD_B : CMD_LOAD_A;
                    if ($urandom_range(0, 3) == 0) begin
                        r = IDX_W'($urandom);
                        c = IDX_W'($urandom);
                    end else if (cmd == CMD_LOAD_A) begin
                        r = IDX_W'($urandom_range(0, ar - 1));
                        c = IDX_W'($urandom_range(0, ac - 1));
                    end else begin
                        r = IDX_W'($urandom_range(0, ac - 1));
                        c = IDX_W'($urandom_range(0, bc - 1));
                    end
                    push_item(cmd, r, c, rand_elem());
                end
                if ($urandom_range(0, 7) == 0)
                    push_item(CMD_RESERVED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
                if (phase == 2 || $urandom_range(0, 4) == 0) drain_input();
                multiply();
            end
            phase++;
        end

        drain_input();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (products.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
